### rtl/core/speech_phrase_endpointer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the phrase endpointer
// Short forms of clocked implication checks, with reset held out.
// ----------------------------------------------------------------------------
`ifndef SPEECH_PHRASE_ENDPOINTER_ASSERT_SVH
`define SPEECH_PHRASE_ENDPOINTER_ASSERT_SVH

// Same-cycle implication
`define SPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("endpointer check failed");

// Next-cycle implication
`define SPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("endpointer check failed");

`endif

### rtl/core/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Types and constants of the speech phrase endpointer.
// ----------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

  localparam int unsigned PROB_W      = 11;
  localparam int unsigned FLEN_W      = 11;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned LEN_W       = 20;
  localparam int unsigned HSUM_W      = 14;
  localparam int unsigned HCNT_W      = 4;
  localparam int unsigned PREROLL_DEPTH = 10;

  localparam logic [FLEN_W-1:0] MAX_FRAME_LEN      = 11'd1024;
  localparam logic [2:0]        CONFIRM_NORMAL     = 3'd2;
  localparam logic [2:0]        CONFIRM_MUTED      = 3'd5;
  localparam logic [2:0]        CONFIRM_MAX        = 3'd7;
  localparam logic [CNT_W-1:0]  CNT_MAX            = 8'd255;
  localparam logic [LEN_W-1:0]  LEN_MAX            = 20'hFFFFF;
  // longest phrase that is still dropped as too short
  localparam logic [LEN_W-1:0]  SHORT_PHRASE_LEN   = 20'd6400;
  localparam logic [HCNT_W-1:0] HIST_FULL          = HCNT_W'(PREROLL_DEPTH);

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned APB_AW      = 5;
  localparam int unsigned APB_DW      = 32;

  // Register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_SPEECH_THR    = 3'd0,
    REG_INTERRUPT_THR = 3'd1,
    REG_SILENCE_THR   = 3'd2,
    REG_HANGOVER      = 3'd3,
    REG_WAKE_THR      = 3'd4,
    REG_WAKE_LEVEL    = 3'd5,
    REG_WAKE_REFRACT  = 3'd6,
    REG_MAX_SAMPLES   = 3'd7
  } reg_idx_t;

  // Result item; aborted sits in the lowest bit once packed
  typedef struct packed {
    logic             speaking;
    logic [LEN_W-1:0] phrase_len;
    logic             forced_by_length;
    logic             sent;
    logic             ended;
    logic [3:0]       preroll_used;
    logic             started_by_wake;
    logic             started;
    logic             aborted;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/speech_phrase_endpointer.sv
// ----------------------------------------------------------------------------
// speech_phrase_endpointer
// Frame-rate phrase start/end detector with wake streak and mute abort.
// ----------------------------------------------------------------------------
// One transfer on the input stream is one audio frame. The block updates its
// phrase state in the cycle the frame is taken and returns exactly one result
// transfer per frame, through the result register. A new frame can be
// taken every cycle: the whole update is a handful of compares and a few
// narrow adds between the input handshake and the result register. A skid
// register behind the result register keeps the input open for one more
// frame while the downstream side stalls; input tready drops only when both
// hold results. Thresholds and limits are written over the APB port and
// should only be changed while no frame is in flight. Frames with a length
// of zero leave the state alone and report the current phrase state.
// ----------------------------------------------------------------------------
`default_nettype none

module speech_phrase_endpointer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input frames
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  // [10:0] speech_prob, [21:11] wake_score, [22] wake_enabled, [23] muted,
  // [34:24] frame_len, [39:35] zero
  input  wire logic [spe_pkg::IN_TDATA_W-1:0]  s_tdata,
  // results
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  // [0] aborted, [1] started, [2] started_by_wake, [6:3] preroll_used,
  // [7] ended, [8] sent, [9] forced_by_length, [29:10] phrase_len,
  // [30] speaking, [31] zero
  output      logic [spe_pkg::OUT_TDATA_W-1:0] m_tdata,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [spe_pkg::APB_AW-1:0]      paddr,
  input  wire logic [spe_pkg::APB_DW-1:0]      pwdata,
  output      logic [spe_pkg::APB_DW-1:0]      prdata,
  output      logic                            pready
);
  import spe_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [PROB_W-1:0] speech_thr, interrupt_thr, silence_thr, wake_thr;
  logic [CNT_W-1:0]  hangover, wake_level, wake_refract;
  logic [LEN_W-1:0]  max_samples;
  logic              cfg_we;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      speech_thr    <= 11'd563;
      interrupt_thr <= 11'd870;
      silence_thr   <= 11'd205;
      hangover      <= 8'd32;
      wake_thr      <= 11'd512;
      wake_level    <= 8'd3;
      wake_refract  <= 8'd60;
      max_samples   <= 20'd240000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SPEECH_THR:    speech_thr    <= pwdata[PROB_W-1:0];
        REG_INTERRUPT_THR: interrupt_thr <= pwdata[PROB_W-1:0];
        REG_SILENCE_THR:   silence_thr   <= pwdata[PROB_W-1:0];
        REG_HANGOVER:      hangover      <= pwdata[CNT_W-1:0];
        REG_WAKE_THR:      wake_thr      <= pwdata[PROB_W-1:0];
        REG_WAKE_LEVEL:    wake_level    <= pwdata[CNT_W-1:0];
        REG_WAKE_REFRACT:  wake_refract  <= pwdata[CNT_W-1:0];
        REG_MAX_SAMPLES:   max_samples   <= pwdata[LEN_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SPEECH_THR:    prdata = APB_DW'(speech_thr);
      REG_INTERRUPT_THR: prdata = APB_DW'(interrupt_thr);
      REG_SILENCE_THR:   prdata = APB_DW'(silence_thr);
      REG_HANGOVER:      prdata = APB_DW'(hangover);
      REG_WAKE_THR:      prdata = APB_DW'(wake_thr);
      REG_WAKE_LEVEL:    prdata = APB_DW'(wake_level);
      REG_WAKE_REFRACT:  prdata = APB_DW'(wake_refract);
      REG_MAX_SAMPLES:   prdata = APB_DW'(max_samples);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input fields
  // --------------------------------------------------------------------------
  logic [PROB_W-1:0] in_prob, in_score;
  logic              in_wake_en, in_muted;
  logic [FLEN_W-1:0] in_flen;
  logic              in_xfer;

  assign in_prob    = s_tdata[10:0];
  assign in_score   = s_tdata[21:11];
  assign in_wake_en = s_tdata[22];
  assign in_muted   = s_tdata[23];
  assign in_flen    = s_tdata[34:24];
  assign in_xfer    = s_tvalid & s_tready;

  // --------------------------------------------------------------------------
  // Phrase state
  // --------------------------------------------------------------------------
  logic              phrase_open, phrase_open_next;
  logic              mute_seen, mute_seen_next;
  logic [CNT_W-1:0]  silence_count, silence_count_next;
  logic [2:0]        confirm_streak, confirm_streak_next;
  logic [CNT_W-1:0]  wake_streak, wake_streak_next;
  logic [CNT_W-1:0]  refractory_left, refractory_left_next;
  logic [LEN_W-1:0]  phrase_samples, phrase_samples_next;
  logic [HCNT_W-1:0] history_count, history_count_next;
  logic [HSUM_W-1:0] history_sum, history_sum_next;
  // frame-length history, oldest first; only written entries are ever read
  logic [FLEN_W-1:0] history_lengths [PREROLL_DEPTH];
  logic [FLEN_W-1:0] history_lengths_next [PREROLL_DEPTH];
  result_t           res_next;

  always_comb begin
    logic [FLEN_W-1:0] flen;
    logic [PROB_W-1:0] active_thr;
    logic [2:0]        confirm_need;
    logic              open_now;
    logic [LEN_W:0]    len_sum;
    logic              timeout, over_limit;

    phrase_open_next     = phrase_open;
    mute_seen_next       = mute_seen;
    silence_count_next   = silence_count;
    confirm_streak_next  = confirm_streak;
    wake_streak_next     = wake_streak;
    refractory_left_next = refractory_left;
    phrase_samples_next  = phrase_samples;
    history_count_next   = history_count;
    history_sum_next     = history_sum;
    history_lengths_next = history_lengths;
    res_next             = '0;
    flen       = (in_flen > MAX_FRAME_LEN) ? MAX_FRAME_LEN : in_flen;
    active_thr = in_muted ? interrupt_thr : speech_thr;
    confirm_need = in_muted ? CONFIRM_MUTED : CONFIRM_NORMAL;
    open_now   = 1'b0;
    len_sum    = '0;
    timeout    = 1'b0;
    over_limit = 1'b0;

    if (in_flen != '0) begin
      // mute onset drops an open phrase
      if (in_muted && !mute_seen && phrase_open) begin
        res_next.aborted    = 1'b1;
        phrase_open_next    = 1'b0;
        silence_count_next  = '0;
        confirm_streak_next = '0;
        phrase_samples_next = '0;
      end
      mute_seen_next = in_muted;

      if (refractory_left != '0) refractory_left_next = refractory_left - 8'd1;

      // history push: append until full, then shift out the oldest
      if (history_count >= HIST_FULL) begin
        history_sum_next = history_sum - HSUM_W'(history_lengths[0]) + HSUM_W'(flen);
        for (int i = 0; i < PREROLL_DEPTH - 1; i++) begin
          history_lengths_next[i] = history_lengths[i+1];
        end
        history_lengths_next[PREROLL_DEPTH-1] = flen;
      end else begin
        for (int i = 0; i < PREROLL_DEPTH; i++) begin
          if (history_count == HCNT_W'(i)) history_lengths_next[i] = flen;
        end
        history_count_next = history_count + 4'd1;
        history_sum_next   = history_sum + HSUM_W'(flen);
      end

      // wake streak
      if (in_wake_en && refractory_left_next == '0) begin
        if (in_score >= wake_thr) begin
          if (wake_streak != CNT_MAX) wake_streak_next = wake_streak + 8'd1;
          if (wake_streak_next >= wake_level && !phrase_open_next) begin
            open_now                 = 1'b1;
            res_next.started_by_wake = 1'b1;
            wake_streak_next         = '0;
            refractory_left_next     = wake_refract;
          end
        end else begin
          wake_streak_next = '0;
        end
      end

      // speech confirmation and silence run
      if (in_prob >= active_thr) begin
        silence_count_next = '0;
        if (!phrase_open_next && !open_now) begin
          if (confirm_streak_next != CONFIRM_MAX)
            confirm_streak_next = confirm_streak_next + 3'd1;
          if (confirm_streak_next >= confirm_need) open_now = 1'b1;
        end
      end else begin
        if (!phrase_open_next && !open_now) confirm_streak_next = '0;
        if (in_prob < silence_thr && (phrase_open_next || open_now) &&
            silence_count_next != CNT_MAX)
          silence_count_next = silence_count_next + 8'd1;
      end

      // opening: phrase starts with the earlier frames of the history
      if (open_now) begin
        res_next.started      = 1'b1;
        res_next.preroll_used = history_count_next - 4'd1;
        phrase_open_next      = 1'b1;
        confirm_streak_next   = '0;
        phrase_samples_next   = LEN_W'(history_sum_next - HSUM_W'(flen));
      end

      if (phrase_open_next) begin
        len_sum = {1'b0, phrase_samples_next} + (LEN_W+1)'(flen);
        phrase_samples_next = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
        timeout    = silence_count_next >= hangover;
        over_limit = phrase_samples_next >= max_samples;
        if (timeout || over_limit) begin
          res_next.ended            = 1'b1;
          res_next.forced_by_length = over_limit;
          res_next.sent             = phrase_samples_next > SHORT_PHRASE_LEN;
          res_next.phrase_len       = phrase_samples_next;
          phrase_open_next          = 1'b0;
          silence_count_next        = '0;
          phrase_samples_next       = '0;
        end
      end
    end

    if (!res_next.ended) res_next.phrase_len = phrase_samples_next;
    res_next.speaking = phrase_open_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phrase_open     <= 1'b0;
      mute_seen       <= 1'b0;
      silence_count   <= '0;
      confirm_streak  <= '0;
      wake_streak     <= '0;
      refractory_left <= '0;
      phrase_samples  <= '0;
      history_count   <= '0;
      history_sum     <= '0;
    end else if (in_xfer) begin
      phrase_open     <= phrase_open_next;
      mute_seen       <= mute_seen_next;
      silence_count   <= silence_count_next;
      confirm_streak  <= confirm_streak_next;
      wake_streak     <= wake_streak_next;
      refractory_left <= refractory_left_next;
      phrase_samples  <= phrase_samples_next;
      history_count   <= history_count_next;
      history_sum     <= history_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) history_lengths <= history_lengths_next;
  end

  // --------------------------------------------------------------------------
  // Result register with skid stage
  // --------------------------------------------------------------------------
  result_t out_res, skid_res;
  logic    out_valid, skid_valid;
  logic    out_xfer;

  assign s_tready = ~skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res};
  assign out_xfer = out_valid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // input is closed; drain skid into the output when it frees up
        if (out_xfer) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (in_xfer) begin
        if (!out_valid || out_xfer) out_valid <= 1'b1;
        else                        skid_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) out_res <= skid_res;
    end else if (in_xfer) begin
      if (!out_valid || out_xfer) out_res  <= res_next;
      else                        skid_res <= res_next;
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`include "speech_phrase_endpointer_assert.svh"

  `SPE_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `SPE_ASSERT_NOW(a_hist_count_range, 1'b1, history_count <= HIST_FULL)
  `SPE_ASSERT_NOW(a_open_has_samples, phrase_open, phrase_samples != '0)
  `SPE_ASSERT_NOW(a_sent_needs_end, out_valid && out_res.sent, out_res.ended)
  `SPE_ASSERT_NEXT(a_stall_fills_skid, in_xfer && out_valid && !m_tready, skid_valid)

endmodule

`default_nettype wire

### tb/speech_phrase_endpointer_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// speech_phrase_endpointer_checker
// Watches the frame, result and APB channels of the endpointer, keeps its
// own copy of the phrase state and registers, predicts the result of every
// accepted frame and compares the results field by field in order.
// ---------------------------------------------------------------------------
module speech_phrase_endpointer_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [spe_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [spe_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spe_pkg::APB_AW-1:0]      paddr,
  input  logic [spe_pkg::APB_DW-1:0]      pwdata,
  input  logic                            pready,
  output int                              err_count,
  output int                              pending
);
  import spe_pkg::*;

  // register values after reset
  localparam logic [PROB_W-1:0] SPEECH_THR_RST    = 11'd563;
  localparam logic [PROB_W-1:0] INTERRUPT_THR_RST = 11'd870;
  localparam logic [PROB_W-1:0] SILENCE_THR_RST   = 11'd205;
  localparam logic [CNT_W-1:0]  HANGOVER_RST      = 8'd32;
  localparam logic [PROB_W-1:0] WAKE_THR_RST      = 11'd512;
  localparam logic [CNT_W-1:0]  WAKE_LEVEL_RST    = 8'd3;
  localparam logic [CNT_W-1:0]  REFRACT_RST       = 8'd60;
  localparam logic [LEN_W-1:0]  MAX_SAMPLES_RST   = 20'd240000;

  logic [PROB_W-1:0] thr_speech, thr_intr, thr_sil, thr_wake;
  logic [CNT_W-1:0]  hang_len, wake_level, refract_len;
  logic [LEN_W-1:0]  len_limit;

  logic              in_phrase, mute_prev;
  logic [CNT_W-1:0]  silent_run, wake_run, refract_left;
  logic [2:0]        confirm_run;
  logic [LEN_W-1:0]  phrase_acc;
  logic [FLEN_W-1:0] hist_len [PREROLL_DEPTH];
  logic [HCNT_W-1:0] hist_fill;
  logic [HSUM_W-1:0] hist_total;

  result_t awaited_results[$];
  int      n_checked;

  initial begin
    err_count = 0;
    n_checked = 0;
  end

  task automatic log_mismatch(input string what);
    $display("ERROR: result %0d: %s", n_checked, what);
    err_count++;
  endtask

  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got)
      log_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [APB_DW-1:0] d);
    case (reg_idx_t'(idx))
      REG_SPEECH_THR:    thr_speech  = d[PROB_W-1:0];
      REG_INTERRUPT_THR: thr_intr    = d[PROB_W-1:0];
      REG_SILENCE_THR:   thr_sil     = d[PROB_W-1:0];
      REG_HANGOVER:      hang_len    = d[CNT_W-1:0];
      REG_WAKE_THR:      thr_wake    = d[PROB_W-1:0];
      REG_WAKE_LEVEL:    wake_level  = d[CNT_W-1:0];
      REG_WAKE_REFRACT:  refract_len = d[CNT_W-1:0];
      REG_MAX_SAMPLES:   len_limit   = d[LEN_W-1:0];
    endcase
  endtask

  // shift register of the last frame lengths with a running total
  task automatic remember_len(input logic [FLEN_W-1:0] len);
    if (hist_fill >= HIST_FULL) begin
      hist_total -= HSUM_W'(hist_len[0]);
      for (int i = 0; i < PREROLL_DEPTH - 1; i++)
        hist_len[i] = hist_len[i + 1];
      hist_len[PREROLL_DEPTH-1] = len;
    end else begin
      hist_len[hist_fill] = len;
      hist_fill++;
    end
    hist_total += HSUM_W'(len);
  endtask

  // phrase starts with the earlier frames of the history, not the current one
  task automatic open_phrase(input logic [FLEN_W-1:0] cur, output logic [3:0] frames_before);
    in_phrase     = 1'b1;
    confirm_run   = '0;
    phrase_acc    = LEN_W'(hist_total - HSUM_W'(cur));
    frames_before = hist_fill - 1'b1;
  endtask

  task automatic predict_result(input logic [PROB_W-1:0] prob, score, input logic wen, mute,
                                input logic [FLEN_W-1:0] flen_raw, output result_t res);
    logic [FLEN_W-1:0] flen;
    logic [PROB_W-1:0] thr;
    logic [2:0]        need;
    logic [LEN_W:0]    grown;
    logic [3:0]        pre;
    res = '0;
    if (flen_raw != '0) begin
      flen = (flen_raw > MAX_FRAME_LEN) ? MAX_FRAME_LEN : flen_raw;
      // mute onset drops an open phrase
      if (mute && !mute_prev && in_phrase) begin
        res.aborted = 1'b1;
        in_phrase   = 1'b0;
        silent_run  = '0;
        confirm_run = '0;
        phrase_acc  = '0;
      end
      mute_prev = mute;
      thr  = mute ? thr_intr : thr_speech;
      need = mute ? CONFIRM_MUTED : CONFIRM_NORMAL;
      if (refract_left != '0)
        refract_left--;
      remember_len(flen);

      if (wen && refract_left == '0) begin
        if (score >= thr_wake) begin
          if (wake_run != CNT_MAX)
            wake_run++;
          if (wake_run >= wake_level && !in_phrase) begin
            open_phrase(flen, pre);
            res.preroll_used    = pre;
            res.started         = 1'b1;
            res.started_by_wake = 1'b1;
            wake_run            = '0;
            refract_left        = refract_len;
          end
        end else begin
          wake_run = '0;
        end
      end

      if (prob >= thr) begin
        silent_run = '0;
        if (!in_phrase) begin
          if (confirm_run != CONFIRM_MAX)
            confirm_run++;
          if (confirm_run >= need) begin
            open_phrase(flen, pre);
            res.preroll_used = pre;
            res.started      = 1'b1;
          end
        end
      end else begin
        if (!in_phrase)
          confirm_run = '0;
        if (prob < thr_sil && in_phrase && silent_run != CNT_MAX)
          silent_run++;
      end

      if (in_phrase) begin
        grown      = {1'b0, phrase_acc} + (LEN_W + 1)'(flen);
        phrase_acc = (grown > {1'b0, LEN_MAX}) ? LEN_MAX : grown[LEN_W-1:0];
        if (silent_run >= hang_len || phrase_acc >= len_limit) begin
          res.ended            = 1'b1;
          res.forced_by_length = (phrase_acc >= len_limit);
          res.sent             = (phrase_acc > SHORT_PHRASE_LEN);
          res.phrase_len       = phrase_acc;
          in_phrase            = 1'b0;
          silent_run           = '0;
          phrase_acc           = '0;
        end
      end
    end
    if (!res.ended)
      res.phrase_len = phrase_acc;
    res.speaking = in_phrase;
  endtask

  always @(posedge clk) begin : watch
    result_t want, got, fresh;
    if (rst) begin
      thr_speech   = SPEECH_THR_RST;
      thr_intr     = INTERRUPT_THR_RST;
      thr_sil      = SILENCE_THR_RST;
      hang_len     = HANGOVER_RST;
      thr_wake     = WAKE_THR_RST;
      wake_level   = WAKE_LEVEL_RST;
      refract_len  = REFRACT_RST;
      len_limit    = MAX_SAMPLES_RST;
      in_phrase    = 1'b0;
      mute_prev    = 1'b0;
      silent_run   = '0;
      confirm_run  = '0;
      wake_run     = '0;
      refract_left = '0;
      phrase_acc   = '0;
      hist_fill    = '0;
      hist_total   = '0;
      for (int i = 0; i < PREROLL_DEPTH; i++)
        hist_len[i] = '0;
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        write_cfg(paddr[4:2], pwdata);

      // a result leaves from the result register, never with its own frame, so compare first
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[30:0]);
        if (awaited_results.size() == 0) begin
          log_mismatch("result transfer with no frame outstanding");
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          check_field("aborted", want.aborted, got.aborted);
          check_field("started", want.started, got.started);
          check_field("started_by_wake", want.started_by_wake, got.started_by_wake);
          check_field("preroll_used", want.preroll_used, got.preroll_used);
          check_field("ended", want.ended, got.ended);
          check_field("sent", want.sent, got.sent);
          check_field("forced_by_length", want.forced_by_length, got.forced_by_length);
          check_field("phrase_len", want.phrase_len, got.phrase_len);
          check_field("speaking", want.speaking, got.speaking);
          check_field("pad bit", 0, m_tdata[31]);
        end
        n_checked++;
      end

      if (s_tvalid && s_tready) begin
        predict_result(s_tdata[10:0], s_tdata[21:11], s_tdata[22], s_tdata[23],
                       s_tdata[34:24], fresh);
        awaited_results.insert(awaited_results.size(), fresh);
      end
    end
    pending <= awaited_results.size();
  end

endmodule

### tb/speech_phrase_endpointer_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// speech_phrase_endpointer_tb
// Drives audio frames and register writes into the phrase endpointer and
// lets the checker predict and compare every result. A short directed run
// hits empty and oversized frames, confirm, mute onset, muted start, wake
// start, refractory and a start that closes at once; then scenario-based
// random traffic runs under several register settings, extremes included.
// ---------------------------------------------------------------------------
module speech_phrase_endpointer_tb;
  import spe_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000; // cycles with no transfer at all
  localparam int DRAIN_CYCLES   = 6;    // result register + skid, with margin

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // [10:0] speech_prob, [21:11] wake_score, [22] wake_enabled, [23] muted,
  // [34:24] frame_len, [39:35] zero
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // [0] aborted, [1] started, [2] started_by_wake, [6:3] preroll_used,
  // [7] ended, [8] sent, [9] forced_by_length, [29:10] phrase_len,
  // [30] speaking, [31] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [APB_AW-1:0]      paddr    = '0;
  logic [APB_DW-1:0]      pwdata   = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  int err_count;
  int pending;

  // stimulus-side copy of the registers, used only to shape traffic
  logic [APB_DW-1:0] cfg_now [8];
  bit  no_gaps = 1'b0;
  int  frames_in = 0, frames_empty = 0, n_settings = 0;
  int  n_opened = 0, n_closed = 0, n_aborted = 0;
  int  quiet_cycles = 0;

  always #6 clk = ~clk;

  speech_phrase_endpointer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  speech_phrase_endpointer_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .err_count (err_count),
    .pending   (pending)
  );

  // Result side: about one stall cycle in five, none while no_gaps is set.
  always @(posedge clk)
    m_tready <= !rst && (no_gaps || $urandom_range(99) >= 20);

  // Tally of phrase events for the closing summary.
  always @(posedge clk) begin : tally
    result_t r;
    r = result_t'(m_tdata[30:0]);
    if (!rst && m_tvalid && m_tready) begin
      if (r.started) n_opened++;
      if (r.ended)   n_closed++;
      if (r.aborted) n_aborted++;
    end
  end

  // Watchdog: counts cycles in which nothing moves on any channel.
  always @(posedge clk)
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("TIMEOUT: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [APB_DW-1:0] reg_mask(input reg_idx_t idx);
    case (idx)
      REG_HANGOVER, REG_WAKE_LEVEL, REG_WAKE_REFRACT: return 32'hFF;
      REG_MAX_SAMPLES:                                return 32'hFFFFF;
      default:                                        return 32'h7FF;
    endcase
  endfunction

  // Two-phase APB write; register takes the value at the access edge.
  // The trailing idle cycle keeps back-to-back writes free of double drives.
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    cfg_now[idx] = data & reg_mask(idx);
  endtask

  task automatic program_regs(input logic [APB_DW-1:0] speech, intr, sil, hang,
                              wake_thr, wake_lvl, refract, max_len);
    write_reg(REG_SPEECH_THR, speech);
    write_reg(REG_INTERRUPT_THR, intr);
    write_reg(REG_SILENCE_THR, sil);
    write_reg(REG_HANGOVER, hang);
    write_reg(REG_WAKE_THR, wake_thr);
    write_reg(REG_WAKE_LEVEL, wake_lvl);
    write_reg(REG_WAKE_REFRACT, refract);
    write_reg(REG_MAX_SAMPLES, max_len);
    n_settings++;
  endtask

  // One frame transfer. tvalid stays up across back-to-back frames and
  // only drops for a random gap or when the stream is parked.
  task automatic send_frame(input logic [10:0] prob, score, input logic wen, mute,
                            input logic [10:0] flen);
    if (!no_gaps && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, flen, mute, wen, score, prob};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (flen != '0) frames_in++;
    else            frames_empty++;
  endtask

  // Park the input and wait until every frame has its result back.
  // pending is updated at the clock edge, so the task waits on the clock before it reads pending.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [10:0] rand11();
    return 11'($urandom_range(0, 2047));
  endfunction

  function automatic logic [10:0] at_or_above(input logic [10:0] thr);
    return 11'($urandom_range(32'(thr), 2047));
  endfunction

  function automatic logic [10:0] below(input logic [10:0] thr);
    return (thr == '0) ? 11'd0 : 11'($urandom_range(0, 32'(thr) - 1));
  endfunction

  // Mostly ordinary lengths; some empty, minimal, full and oversized frames.
  function automatic logic [10:0] frame_len_pick();
    int r;
    r = $urandom_range(99);
    if (r < 3)       return 11'd0;
    else if (r < 9)  return 11'($urandom_range(1025, 2047));
    else if (r < 13) return 11'd1;
    else if (r < 18) return 11'd1024;
    else             return 11'($urandom_range(1, 1024));
  endfunction

  task automatic send_quiet();
    send_frame(below(cfg_now[REG_SILENCE_THR][10:0]), rand11(),
               $urandom_range(3) == 0, 1'b0, frame_len_pick());
  endtask

  // Scenario mix: utterances (lead-in, speech burst, hangover-length
  // silence), wake streaks, mute episodes, and plain noise.
  task automatic run_traffic(input int n_items);
    int base, pick, hang, lvl;
    bit paused;
    base   = frames_in;
    paused = 1'b0;
    hang   = int'(cfg_now[REG_HANGOVER]);
    lvl    = int'(cfg_now[REG_WAKE_LEVEL]);
    while (frames_in - base < n_items) begin
      if (!paused && frames_in - base >= n_items / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat ($urandom_range(0, 2)) send_quiet();
        repeat ($urandom_range(1, 12))
          send_frame(at_or_above(cfg_now[REG_SPEECH_THR][10:0]), rand11(),
                     $urandom_range(3) == 0, 1'b0, frame_len_pick());
        repeat ($urandom_range(0, hang + 2)) send_quiet();
      end else if (pick < 60) begin
        repeat ($urandom_range(1, lvl + 1))
          send_frame(rand11(), at_or_above(cfg_now[REG_WAKE_THR][10:0]), 1'b1, 1'b0,
                     frame_len_pick());
      end else if (pick < 72) begin
        repeat ($urandom_range(1, 7))
          send_frame(($urandom_range(4) == 0) ? rand11()
                                               : at_or_above(cfg_now[REG_INTERRUPT_THR][10:0]),
                     rand11(), 1'($urandom_range(1)), 1'b1, frame_len_pick());
      end else begin
        repeat ($urandom_range(1, 4))
          send_frame(rand11(), rand11(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     frame_len_pick());
      end
    end
  endtask

  // Directed frames: hangover 2, trigger 2, refractory 3, limit 6000.
  task automatic directed_frames();
    send_frame(11'd2047, 11'd0, 1'b0, 1'b0, 11'd0);       // empty frame
    send_frame(11'd0, 11'd2047, 1'b0, 1'b0, 11'd2047);    // oversized, clamps
    send_frame(11'd1024, 11'd0, 1'b0, 1'b0, 11'd1024);    // first confirm
    send_frame(11'd2047, 11'd2047, 1'b0, 1'b0, 11'd1);    // second confirm opens
    send_frame(11'd700, 11'd0, 1'b0, 1'b0, 11'd1024);
    send_frame(11'd0, 11'd0, 1'b0, 1'b0, 11'd1024);       // silence
    send_frame(11'd0, 11'd0, 1'b0, 1'b0, 11'd1024);       // hangover closes
    send_frame(11'd1024, 11'd0, 1'b0, 1'b0, 11'd512);
    send_frame(11'd1024, 11'd0, 1'b0, 1'b0, 11'd512);     // opens again, closed at once by the limit
    send_frame(11'd0, 11'd0, 1'b0, 1'b1, 11'd256);        // mute onset, no phrase open to abort
    repeat (5) send_frame(11'd900, 11'd0, 1'b0, 1'b1, 11'd1024); // muted start
    send_frame(11'd1024, 11'd0, 1'b0, 1'b1, 11'd1024);    // muted confirm, no phrase open
    send_frame(11'd0, 11'd2047, 1'b1, 1'b0, 11'd300);     // wake streak 1
    send_frame(11'd0, 11'd1024, 1'b1, 1'b0, 11'd300);     // wake streak 2 opens
    send_frame(11'd0, 11'd2047, 1'b1, 1'b0, 11'd300);     // refractory, ignored
    send_frame(11'd0, 11'd0, 1'b1, 1'b0, 11'd300);
    send_frame(11'd0, 11'd0, 1'b0, 1'b0, 11'd300);
    send_frame(11'd2047, 11'd2047, 1'b1, 1'b1, 11'd1024); // mute with wake
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_regs(563, 870, 205, 2, 512, 2, 3, 6000);
    directed_frames();
    settle();

    // values the block comes out of reset with
    program_regs(563, 870, 205, 32, 512, 3, 60, 240000);
    run_traffic(280);
    settle();

    // short limits, with both sides running flat out
    no_gaps = 1'b1;
    program_regs(400, 700, 300, 3, 600, 1, 0, 5000);
    run_traffic(160);
    settle();
    no_gaps = 1'b0;

    // every register at zero: each phrase that opens closes at once
    program_regs(0, 0, 0, 0, 0, 0, 0, 0);
    run_traffic(120);
    settle();

    // every register at its all-ones value
    program_regs(32'h7FF, 32'h7FF, 32'h7FF, 32'hFF, 32'h7FF, 32'hFF, 32'hFF, 32'hFFFFF);
    run_traffic(160);
    settle();

    // full-scale thresholds, minimal limits
    program_regs(1024, 1024, 1024, 1, 1024, 1, 255, 1);
    run_traffic(100);
    settle();

    // random settings, junk in the unused upper bits
    repeat (2) begin
      program_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
      run_traffic(150);
      settle();
    end

    $display("Summary: %0d frames plus %0d empty ones under %0d register settings",
             frames_in, frames_empty, n_settings);
    $display("Summary: %0d phrases opened, %0d closed, %0d aborted by mute onset",
             n_opened, n_closed, n_aborted);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### speech_phrase_endpointer.f
+incdir+rtl/core
rtl/core/spe_pkg.sv
rtl/core/speech_phrase_endpointer.sv
tb/speech_phrase_endpointer_checker.sv
tb/speech_phrase_endpointer_tb.sv
